/* hdl/bcr_pkg.sv */
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared types, widths and codes of the bisection cubic root unit.
// ----------------------------------------------------------------------------
package bcr_pkg;

    // fixed-point format of the interval ends
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 20;

    // result and internal function widths
    localparam int F_OUT_WIDTH = 56;
    localparam int F_WIDTH     = 64;

    // configuration register widths
    localparam int FTOL_W = 62;
    localparam int XTOL_W = 32;
    localparam int ITER_W = 8;

    // reset values of the configuration registers
    localparam logic [FTOL_W-1:0] FTOL_RESET = FTOL_W'(1);
    localparam logic [XTOL_W-1:0] XTOL_RESET = XTOL_W'(1);
    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(64);

    // apb port
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_F_TOL      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_TOL      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_DONE           = 2'd0;
    localparam logic [1:0] STATUS_ENDS_EQUAL     = 2'd1;
    localparam logic [1:0] STATUS_NO_SIGN_CHANGE = 2'd2;

    // iterative multiplier geometry: 32-bit chunks of the multiplicand
    localparam int CHUNK_W = 32;
    localparam int PROD_W  = CHUNK_W + COORD_WIDTH;
    localparam int NC1     = (COORD_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int NC2     = (2 * COORD_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int OPND_W  = NC2 * CHUNK_W;
    localparam int ACC_W   = 3 * COORD_WIDTH;
    localparam int QW      = (ACC_W > F_WIDTH) ? ACC_W : F_WIDTH;
    localparam int CNT_W   = (NC2 > 1) ? $clog2(NC2) : 1;

    // cube magnitude saturates here
    localparam logic [F_WIDTH-1:0] CUBE_CLAMP = F_WIDTH'(1) << 62;

    // interval width compare
    localparam int DW    = COORD_WIDTH + 1;
    localparam int CMP_W = (DW > XTOL_W) ? DW : XTOL_W;

    // request and response payloads
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] left_end;
        logic signed [COORD_WIDTH-1:0] right_end;
    } req_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] root;
        logic signed [F_OUT_WIDTH-1:0] f_at_root;
        logic [ITER_W-1:0]             iterations;
        logic [1:0]                    status;
    } rsp_t;

    // operand source of the cubic unit
    typedef enum logic [1:0] {
        SRC_A   = 2'd0,
        SRC_B   = 2'd1,
        SRC_M   = 2'd2,
        SRC_MID = 2'd3
    } src_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       start;
        src_t       src;
        logic       store_fa;
        logic       store_fb;
        logic       store_fm;
        logic       init_mid;
        logic       set_mid;
        logic       update;
        logic       write;
        logic [1:0] wr_status;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic ends_equal;
        logic same_sign;
        logic more;
        logic small_f;
        logic cubic_done;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/bisection_cubic_root_unit.sv */
// The unit takes one request at a time; the next is taken once the result is in
// the output register. A small f can stop the halving loop early, and equal ends
// or no sign change end the request with a failure status. Each cube evaluation
// runs on the shared chunked multiplier. Reset clears control state and sets the
// tolerances to 1 and the iteration limit to 64.
// ----------------------------------------------------------------------------
// bisection_cubic_root_unit
// Finds a root of x^3 - x - 1 on a fixed-point interval by bisection.
// ----------------------------------------------------------------------------
module bisection_cubic_root_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  bcr_pkg::req_t                req_data,
    // response channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output bcr_pkg::rsp_t                rsp_data,
    // apb configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcr_pkg::ADDR_W-1:0]   paddr,
    input  logic [bcr_pkg::DATA_W-1:0]   pwdata,
    output logic [bcr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import bcr_pkg::*;

    logic [FTOL_W-1:0]    f_tol_reg;
    logic [XTOL_W-1:0]    x_tol_reg;
    logic [ITER_W-1:0]    iter_limit_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    ctrl_cmd_t            cmd;
    dp_status_t           status;
    logic                 idle;

    // register decode
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_tol_reg      <= FTOL_RESET;
            x_tol_reg      <= XTOL_RESET;
            iter_limit_reg <= ITER_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_F_TOL:      f_tol_reg      <= pwdata[FTOL_W-1:0];
                REG_X_TOL:      x_tol_reg      <= pwdata[XTOL_W-1:0];
                REG_ITER_LIMIT: iter_limit_reg <= pwdata[ITER_W-1:0];
                default:        f_tol_reg      <= f_tol_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_F_TOL:      prdata = DATA_W'(f_tol_reg);
            REG_X_TOL:      prdata = DATA_W'(x_tol_reg);
            REG_ITER_LIMIT: prdata = DATA_W'(iter_limit_reg);
            default:        prdata = '0;
        endcase
    end

    // request taken only while the controller waits
    assign req_stall = !idle;

    bcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .cmd       (cmd),
        .idle      (idle)
    );

    bcr_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_data   (req_data),
        .rsp_stall  (rsp_stall),
        .f_tol      (f_tol_reg),
        .x_tol      (x_tol_reg),
        .iter_limit (iter_limit_reg),
        .cmd        (cmd),
        .status     (status),
        .rsp_valid  (rsp_valid),
        .rsp_data   (rsp_data)
    );

`ifndef ASSERT_OFF
    // a failed request carries an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != STATUS_DONE) |->
            (rsp_data.root == '0) && (rsp_data.f_at_root == '0)
            && (rsp_data.iterations == '0))
        else $error("failed request with nonzero payload");

    // halving count never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == STATUS_DONE) |->
            (rsp_data.iterations <= iter_limit_reg))
        else $error("iteration count above limit");

    // result written only when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> status.out_free)
        else $error("result overwrites a pending response");

    // interval loaded only on an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> req_valid && !req_stall)
        else $error("interval loaded without a request");
`endif

endmodule

/* hdl/bcr_cubic.sv */
// ----------------------------------------------------------------------------
// bcr_cubic
// Iterative evaluation of f(x) = x^3 - x - 1 in fixed point, chunked multiply.
// ----------------------------------------------------------------------------
module bcr_cubic (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [bcr_pkg::COORD_WIDTH-1:0] x,
    output logic                                  done,
    output logic signed [bcr_pkg::F_WIDTH-1:0]     f
);
    import bcr_pkg::*;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_MUL  = 5'b00010,
        C_ACC  = 5'b00100,
        C_SIGN = 5'b01000,
        C_SUB  = 5'b10000
    } cstate_t;

    localparam logic signed [F_WIDTH-1:0] FIX_ONE = F_WIDTH'(1) << FRAC_BITS;

    cstate_t                       state_reg, state_next;
    logic signed [COORD_WIDTH-1:0] x_reg;
    logic                          neg_reg;
    logic [COORD_WIDTH-1:0]        mag_reg;
    logic [OPND_W-1:0]             opnd_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic [CNT_W-1:0]              chunk_reg;
    logic                          phase_reg;
    logic signed [F_WIDTH-1:0]     c_reg;
    logic signed [F_WIDTH-1:0]     f_reg;
    logic                          done_reg;

    logic [COORD_WIDTH-1:0] mag_in;
    logic [CHUNK_W-1:0]     opnd_chunk;
    logic [ACC_W-1:0]       acc_sum;
    logic                   last_chunk;
    logic [QW-1:0]          q;
    logic [F_WIDTH-1:0]     cmag;

    // magnitude of the operand
    assign mag_in     = x[COORD_WIDTH-1] ? $unsigned(-x) : $unsigned(x);

    // partial product accumulate
    assign opnd_chunk = opnd_reg[chunk_reg*CHUNK_W +: CHUNK_W];
    assign acc_sum    = acc_reg + (ACC_W'(prod_reg) << (chunk_reg * CHUNK_W));
    assign last_chunk = phase_reg ? (chunk_reg == CNT_W'(NC2 - 1))
                                  : (chunk_reg == CNT_W'(NC1 - 1));

    // scale down, saturate
    assign q    = QW'(acc_reg) >> (2 * FRAC_BITS);
    assign cmag = (q > QW'(CUBE_CLAMP)) ? CUBE_CLAMP : q[F_WIDTH-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                    state_next = C_MUL;
            end
            C_MUL:  state_next = C_ACC;
            C_ACC:
            begin
                if (last_chunk && phase_reg)
                    state_next = C_SIGN;
                else
                    state_next = C_MUL;
            end
            C_SIGN: state_next = C_SUB;
            C_SUB:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_SUB);
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_reg     <= x;
                    neg_reg   <= x[COORD_WIDTH-1];
                    mag_reg   <= mag_in;
                    opnd_reg  <= OPND_W'(mag_in);
                    acc_reg   <= '0;
                    chunk_reg <= '0;
                    phase_reg <= 1'b0;
                end
            end
            C_MUL:
            begin
                prod_reg <= PROD_W'(opnd_chunk) * PROD_W'(mag_reg);
            end
            C_ACC:
            begin
                if (!last_chunk)
                begin
                    acc_reg   <= acc_sum;
                    chunk_reg <= chunk_reg + 1'b1;
                end
                else if (!phase_reg)
                begin
                    // square done, it becomes the multiplicand
                    opnd_reg  <= OPND_W'(acc_sum[2*COORD_WIDTH-1:0]);
                    acc_reg   <= '0;
                    chunk_reg <= '0;
                    phase_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
            C_SIGN:
            begin
                c_reg <= neg_reg ? -$signed(cmag) : $signed(cmag);
            end
            C_SUB:
            begin
                f_reg <= c_reg - F_WIDTH'(x_reg) - FIX_ONE;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign f    = f_reg;

endmodule

/* hdl/bcr_datapath.sv */
// ----------------------------------------------------------------------------
// bcr_datapath
// Interval registers, midpoint and sign logic, cubic unit and result register.
// ----------------------------------------------------------------------------
module bcr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcr_pkg::req_t                 req_data,
    input  logic                          rsp_stall,
    input  logic [bcr_pkg::FTOL_W-1:0]    f_tol,
    input  logic [bcr_pkg::XTOL_W-1:0]    x_tol,
    input  logic [bcr_pkg::ITER_W-1:0]    iter_limit,
    input  bcr_pkg::ctrl_cmd_t            cmd,
    output bcr_pkg::dp_status_t           status,
    output logic                          rsp_valid,
    output bcr_pkg::rsp_t                 rsp_data
);
    import bcr_pkg::*;

    logic signed [COORD_WIDTH-1:0] a_reg, b_reg, m_reg;
    logic signed [F_WIDTH-1:0]     fa_reg, fb_reg, fm_reg;
    logic [F_WIDTH-1:0]            fm_mag_reg;
    logic [ITER_W-1:0]             k_reg;
    logic                          rsp_valid_reg;
    rsp_t                          rsp_reg;

    logic signed [DW-1:0]          diff;
    logic signed [DW-1:0]          mid_wide;
    logic signed [COORD_WIDTH-1:0] mid;
    logic signed [COORD_WIDTH-1:0] cubic_x;
    logic                          cubic_done;
    logic signed [F_WIDTH-1:0]     cubic_f;
    logic                          fa_zero, fb_zero;
    rsp_t                          rsp_next;

    // width and midpoint of the interval
    assign diff     = {b_reg[COORD_WIDTH-1], b_reg} - {a_reg[COORD_WIDTH-1], a_reg};
    assign mid_wide = {a_reg[COORD_WIDTH-1], a_reg} + (diff >>> 1);
    assign mid      = mid_wide[COORD_WIDTH-1:0];

    assign fa_zero  = (fa_reg == '0);
    assign fb_zero  = (fb_reg == '0);

    // cubic operand select
    always_comb
    begin
        case (cmd.src)
            SRC_A:   cubic_x = a_reg;
            SRC_B:   cubic_x = b_reg;
            SRC_M:   cubic_x = m_reg;
            SRC_MID: cubic_x = mid;
            default: cubic_x = m_reg;
        endcase
    end

    bcr_cubic u_cubic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .x     (cubic_x),
        .done  (cubic_done),
        .f     (cubic_f)
    );

    // status to the controller
    always_comb
    begin
        status.ends_equal = (a_reg == b_reg);
        status.same_sign  = !fa_zero && !fb_zero
                            && (fa_reg[F_WIDTH-1] == fb_reg[F_WIDTH-1]);
        status.more       = (CMP_W'($unsigned(diff)) > CMP_W'(x_tol))
                            && (k_reg < iter_limit);
        status.small_f    = (fm_mag_reg < F_WIDTH'(f_tol));
        status.cubic_done = cubic_done;
        status.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    // interval and function registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (req_data.left_end < req_data.right_end)
            begin
                a_reg <= req_data.left_end;
                b_reg <= req_data.right_end;
            end
            else
            begin
                a_reg <= req_data.right_end;
                b_reg <= req_data.left_end;
            end
            k_reg <= '0;
        end

        if (cmd.store_fa)
            fa_reg <= cubic_f;
        if (cmd.store_fb)
            fb_reg <= cubic_f;
        if (cmd.store_fm)
        begin
            fm_reg     <= cubic_f;
            fm_mag_reg <= cubic_f[F_WIDTH-1] ? $unsigned(-cubic_f) : $unsigned(cubic_f);
        end

        // first midpoint, an exact zero end collapses the interval
        if (cmd.init_mid)
        begin
            if (fa_zero)
            begin
                m_reg <= a_reg;
                b_reg <= a_reg;
            end
            else if (fb_zero)
            begin
                m_reg <= b_reg;
                a_reg <= b_reg;
            end
            else
            begin
                m_reg <= mid;
            end
        end

        if (cmd.set_mid)
            m_reg <= mid;

        // halving step
        if (cmd.update)
        begin
            if ((fm_reg != '0) && !fa_zero
                && (fm_reg[F_WIDTH-1] != fa_reg[F_WIDTH-1]))
            begin
                b_reg <= m_reg;
            end
            else
            begin
                a_reg  <= m_reg;
                fa_reg <= fm_reg;
            end
            k_reg <= k_reg + 1'b1;
        end
    end

    // result payload
    always_comb
    begin
        rsp_next = '0;
        rsp_next.status = cmd.wr_status;
        if (cmd.wr_status == STATUS_DONE)
        begin
            rsp_next.root       = m_reg;
            rsp_next.f_at_root  = cubic_f[F_OUT_WIDTH-1:0];
            rsp_next.iterations = k_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.write)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

/* hdl/bcr_ctrl.sv */
// ----------------------------------------------------------------------------
// bcr_ctrl
// Controller that sequences checks, cube evaluations and halving steps.
// ----------------------------------------------------------------------------
module bcr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  bcr_pkg::dp_status_t status,
    output bcr_pkg::ctrl_cmd_t  cmd,
    output logic                idle
);
    import bcr_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_CHECK_EQ  = 12'b000000000010,
        S_EVAL_A    = 12'b000000000100,
        S_EVAL_B    = 12'b000000001000,
        S_SIGN      = 12'b000000010000,
        S_TEST      = 12'b000000100000,
        S_EVAL_M    = 12'b000001000000,
        S_DECIDE    = 12'b000010000000,
        S_EVAL_F    = 12'b000100000000,
        S_WRITE     = 12'b001000000000,
        S_FAIL_EQ   = 12'b010000000000,
        S_FAIL_SIGN = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK_EQ;
                end
            end
            S_CHECK_EQ:
            begin
                if (status.ends_equal)
                    state_next = S_FAIL_EQ;
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.src    = SRC_A;
                    state_next = S_EVAL_A;
                end
            end
            S_EVAL_A:
            begin
                if (status.cubic_done)
                begin
                    cmd.store_fa = 1'b1;
                    cmd.start    = 1'b1;
                    cmd.src      = SRC_B;
                    state_next   = S_EVAL_B;
                end
            end
            S_EVAL_B:
            begin
                if (status.cubic_done)
                begin
                    cmd.store_fb = 1'b1;
                    state_next   = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (status.same_sign)
                    state_next = S_FAIL_SIGN;
                else
                begin
                    cmd.init_mid = 1'b1;
                    state_next   = S_TEST;
                end
            end
            S_TEST:
            begin
                cmd.start = 1'b1;
                if (status.more)
                begin
                    cmd.set_mid = 1'b1;
                    cmd.src     = SRC_MID;
                    state_next  = S_EVAL_M;
                end
                else
                begin
                    cmd.src    = SRC_M;
                    state_next = S_EVAL_F;
                end
            end
            S_EVAL_M:
            begin
                if (status.cubic_done)
                begin
                    cmd.store_fm = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.small_f)
                begin
                    cmd.start  = 1'b1;
                    cmd.src    = SRC_M;
                    state_next = S_EVAL_F;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_EVAL_F:
            begin
                if (status.cubic_done)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.write     = 1'b1;
                    cmd.wr_status = STATUS_DONE;
                    state_next    = S_IDLE;
                end
            end
            S_FAIL_EQ:
            begin
                if (status.out_free)
                begin
                    cmd.write     = 1'b1;
                    cmd.wr_status = STATUS_ENDS_EQUAL;
                    state_next    = S_IDLE;
                end
            end
            S_FAIL_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.write     = 1'b1;
                    cmd.wr_status = STATUS_NO_SIGN_CHANGE;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign idle = (state_reg == S_IDLE);

endmodule

/* test/bisection_cubic_root_unit_test.sv */
// ----------------------------------------------------------------------------
// bisection_cubic_root_unit_test
// Drives intervals into the bisection root finder, predicts each result with a
// fixed-point model of the search and compares every response field by field.
// Runs through several tolerance and step-limit settings over the apb port.
// ----------------------------------------------------------------------------
module bisection_cubic_root_unit_test;

    import bcr_pkg::*;

    localparam int    RUN_LIMIT   = 2_000_000;
    localparam int    DRAIN_TAIL  = 40;
    localparam int    IDLE_PCT    = 8;
    localparam longint COORD_MIN  = -(longint'(1) <<< (COORD_WIDTH - 1));
    localparam longint COORD_MAX  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint ONE_FIX    = longint'(1) <<< FRAC_BITS;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    req_t                req_data;
    logic                rsp_valid;
    logic                rsp_stall;
    rsp_t                rsp_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // register shadow copies
    logic [FTOL_W-1:0]   ftol_cfg;
    logic [XTOL_W-1:0]   xtol_cfg;
    logic [ITER_W-1:0]   iter_cfg;

    req_t                pending_reqs[$];
    rsp_t                expected_rsps[$];
    logic                req_accepted;
    logic                idle_mode;
    longint              bracket_lo;
    longint              bracket_hi;
    int                  fail_count;
    int                  cycle_count;
    int                  reqs_taken;
    int                  rsps_checked;
    int                  done_count;
    int                  equal_count;
    int                  nosign_count;
    int                  settings_count;

    bisection_cubic_root_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // cube minus x minus one, cube truncated toward zero and clamped
    function automatic longint cubic_value(longint x);
        logic [95:0] cube_mag;
        logic [95:0] scaled;
        logic [63:0] x_mag;
        longint      c;
        x_mag    = (x < 0) ? -x : x;
        cube_mag = {32'd0, x_mag} * {32'd0, x_mag} * {32'd0, x_mag};
        scaled   = cube_mag >> (2 * FRAC_BITS);
        if (scaled > 96'(CUBE_CLAMP))
            scaled = 96'(CUBE_CLAMP);
        c = longint'(scaled[63:0]);
        if (x < 0)
            c = -c;
        return c - x - ONE_FIX;
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // bisection search as the unit should carry it out
    function automatic rsp_t solve_interval(req_t r);
        longint      lo_end;
        longint      hi_end;
        longint      swap_tmp;
        longint      mid;
        longint      f_lo;
        longint      f_hi;
        longint      f_mid;
        longint      f_abs;
        int unsigned steps;
        rsp_t        res;
        lo_end = r.left_end;
        hi_end = r.right_end;
        steps  = 0;
        res    = '0;
        if (lo_end == hi_end)
        begin
            res.status = STATUS_ENDS_EQUAL;
            return res;
        end
        if (lo_end > hi_end)
        begin
            swap_tmp = lo_end;
            lo_end   = hi_end;
            hi_end   = swap_tmp;
        end
        f_lo = cubic_value(lo_end);
        f_hi = cubic_value(hi_end);
        if (sign_of(f_lo) * sign_of(f_hi) > 0)
        begin
            res.status = STATUS_NO_SIGN_CHANGE;
            return res;
        end
        mid = lo_end + ((hi_end - lo_end) >>> 1);
        // an exact zero at an end collapses the interval onto it
        if (f_lo == 0)
        begin
            mid    = lo_end;
            hi_end = lo_end;
        end
        if (f_hi == 0)
        begin
            mid    = hi_end;
            lo_end = hi_end;
        end
        while ((hi_end - lo_end) > longint'(xtol_cfg) && steps < iter_cfg)
        begin
            mid   = lo_end + ((hi_end - lo_end) >>> 1);
            f_mid = cubic_value(mid);
            f_abs = (f_mid < 0) ? -f_mid : f_mid;
            if (f_abs < longint'(ftol_cfg))
                break;
            if (sign_of(f_mid) * sign_of(f_lo) < 0)
                hi_end = mid;
            else
            begin
                lo_end = mid;
                f_lo   = f_mid;
            end
            steps++;
        end
        f_mid          = cubic_value(mid);
        res.root       = mid[COORD_WIDTH-1:0];
        res.f_at_root  = f_mid[F_OUT_WIDTH-1:0];
        res.iterations = steps[ITER_W-1:0];
        res.status     = STATUS_DONE;
        return res;
    endfunction

    function automatic req_t make_pair(longint left, longint right);
        req_t r;
        r.left_end  = left[COORD_WIDTH-1:0];
        r.right_end = right[COORD_WIDTH-1:0];
        return r;
    endfunction

    // mostly intervals around the root with random span, plus noise
    function automatic req_t random_request();
        int unsigned pick;
        int unsigned span_bits;
        longint      lo;
        longint      hi;
        longint      v;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            span_bits = $urandom_range(31);
            lo = bracket_lo - longint'($urandom_range((32'd1 << span_bits) - 1));
            span_bits = $urandom_range(31);
            hi = bracket_hi + longint'($urandom_range((32'd1 << span_bits) - 1));
            if (lo < COORD_MIN)
                lo = COORD_MIN;
            if (hi > COORD_MAX)
                hi = COORD_MAX;
            if ($urandom_range(1) == 1)
                return make_pair(hi, lo);
            return make_pair(lo, hi);
        end
        else if (pick < 85)
            return make_pair(longint'($urandom), longint'($urandom));
        else if (pick < 93)
        begin
            v = longint'($urandom);
            return make_pair(v, v);
        end
        lo = bracket_hi + longint'($urandom_range(32'(COORD_MAX - bracket_hi)));
        hi = bracket_hi + longint'($urandom_range(32'(COORD_MAX - bracket_hi)));
        return make_pair(lo, hi);
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            pending_reqs.push_back(random_request());
    endtask

    // hold off until every request is back, then let the unit settle
    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // one apb transfer, setup then access; pready is always high
    task automatic apb_transfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write a register, mirror it and read it back
    task automatic set_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] want;
        apb_transfer(1'b1, idx, value, readback);
        case (idx)
            REG_F_TOL:
            begin
                ftol_cfg = value[FTOL_W-1:0];
                want     = DATA_W'(ftol_cfg);
            end
            REG_X_TOL:
            begin
                xtol_cfg = value[XTOL_W-1:0];
                want     = DATA_W'(xtol_cfg);
            end
            REG_ITER_LIMIT:
            begin
                iter_cfg = value[ITER_W-1:0];
                want     = DATA_W'(iter_cfg);
            end
            default:
                return;
        endcase
        apb_transfer(1'b0, idx, '0, readback);
        if (readback !== want)
        begin
            $error("register %0d readback: expected %0h, got %0h", idx, want, readback);
            fail_count++;
        end
    endtask

    // request driver and response stall, both changing on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_accepted)
            begin
                if (pending_reqs.size() != 0
                    && !(idle_mode && $urandom_range(99) < IDLE_PCT))
                begin
                    req_data  <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_stall <= idle_mode && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // monitor: predict on request acceptance, check on response acceptance
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n)
        begin
            req_accepted <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(solve_interval(req_data));
                reqs_taken++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response with no request outstanding: root %0d status %0d",
                           rsp_data.root, rsp_data.status);
                    fail_count++;
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    rsps_checked++;
                    case (exp_rsp.status)
                        STATUS_DONE:       done_count++;
                        STATUS_ENDS_EQUAL: equal_count++;
                        default:           nosign_count++;
                    endcase
                    if (rsp_data.root !== exp_rsp.root)
                    begin
                        $error("root: expected %0d, got %0d", exp_rsp.root, rsp_data.root);
                        fail_count++;
                    end
                    if (rsp_data.f_at_root !== exp_rsp.f_at_root)
                    begin
                        $error("f_at_root: expected %0d, got %0d",
                               exp_rsp.f_at_root, rsp_data.f_at_root);
                        fail_count++;
                    end
                    if (rsp_data.iterations !== exp_rsp.iterations)
                    begin
                        $error("iterations: expected %0d, got %0d",
                               exp_rsp.iterations, rsp_data.iterations);
                        fail_count++;
                    end
                    if (rsp_data.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               exp_rsp.status, rsp_data.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("bisection_cubic_root_unit verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic   have_zero;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        rsp_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_accepted   = 1'b0;
        idle_mode      = 1'b1;
        ftol_cfg       = FTOL_RESET;
        xtol_cfg       = XTOL_RESET;
        iter_cfg       = ITER_RESET;
        fail_count     = 0;
        cycle_count    = 0;
        reqs_taken     = 0;
        rsps_checked   = 0;
        done_count     = 0;
        equal_count    = 0;
        nosign_count   = 0;
        settings_count = 1;
        have_zero      = 1'b0;

        // locate the sign change of f next to the real root near 1.3247
        bracket_hi = 64'sd1_380_000;
        while (cubic_value(bracket_hi) < 0)
            bracket_hi++;
        bracket_lo = bracket_hi - 1;
        have_zero  = (cubic_value(bracket_hi) == 0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: orders, equal ends, same sign, extremes, tight brackets
        pending_reqs.push_back(make_pair(ONE_FIX, 2 * ONE_FIX));
        pending_reqs.push_back(make_pair(2 * ONE_FIX, ONE_FIX));
        pending_reqs.push_back(make_pair(5, 5));
        pending_reqs.push_back(make_pair(COORD_MIN, COORD_MIN));
        pending_reqs.push_back(make_pair(COORD_MAX, COORD_MAX));
        pending_reqs.push_back(make_pair(2 * ONE_FIX, 3 * ONE_FIX));
        pending_reqs.push_back(make_pair(-3 * ONE_FIX, -2 * ONE_FIX));
        pending_reqs.push_back(make_pair(COORD_MIN, COORD_MAX));
        pending_reqs.push_back(make_pair(COORD_MAX, COORD_MIN));
        pending_reqs.push_back(make_pair(0, COORD_MAX));
        pending_reqs.push_back(make_pair(-1, 0));
        pending_reqs.push_back(make_pair(-1, COORD_MAX));
        pending_reqs.push_back(make_pair(COORD_MIN, 2 * ONE_FIX));
        pending_reqs.push_back(make_pair(COORD_MIN, -1));
        pending_reqs.push_back(make_pair(COORD_MIN + 1, COORD_MAX - 1));
        pending_reqs.push_back(make_pair(longint'(32'sh5555_5555),
                                         longint'(32'shAAAA_AAAA)));
        pending_reqs.push_back(make_pair(bracket_lo, bracket_hi));
        pending_reqs.push_back(make_pair(bracket_hi, bracket_lo));
        pending_reqs.push_back(make_pair(bracket_lo - 1, bracket_hi + 1));
        // exact zero at either end when the format has one
        pending_reqs.push_back(make_pair(bracket_hi, 2 * ONE_FIX));
        pending_reqs.push_back(make_pair(0, bracket_hi));
        pending_reqs.push_back(make_pair(ONE_FIX, bracket_hi));

        // reset settings, random part with a full hold-off in the middle
        queue_random(120);
        drain();
        idle_mode = 1'b0;
        queue_random(130);
        drain();
        idle_mode = 1'b1;

        // no tolerance at all, longest step limit
        set_register(REG_F_TOL, '0);
        set_register(REG_X_TOL, '0);
        set_register(REG_ITER_LIMIT, DATA_W'({ITER_W{1'b1}}));
        settings_count++;
        pending_reqs.push_back(make_pair(COORD_MIN, COORD_MAX));
        pending_reqs.push_back(make_pair(bracket_lo, bracket_hi));
        queue_random(28);
        drain();

        // widest tolerances, no halving allowed; stray write must be ignored
        set_register(REG_F_TOL, DATA_W'({FTOL_W{1'b1}}));
        set_register(REG_X_TOL, DATA_W'({XTOL_W{1'b1}}));
        set_register(REG_ITER_LIMIT, '0);
        set_register(REG_UNUSED, {DATA_W{1'b1}});
        settings_count++;
        queue_random(60);
        drain();

        // moderate tolerances, short step limit
        set_register(REG_F_TOL, DATA_W'(1) << 15);
        set_register(REG_X_TOL, DATA_W'(1) << 10);
        set_register(REG_ITER_LIMIT, DATA_W'(12));
        settings_count++;
        queue_random(150);
        drain();

        // early stop below one in f, exact width
        set_register(REG_F_TOL, DATA_W'(ONE_FIX));
        set_register(REG_X_TOL, '0);
        set_register(REG_ITER_LIMIT, DATA_W'(40));
        settings_count++;
        queue_random(100);
        drain();

        $display("covered %0d requests under %0d register settings, %0d responses checked",
                 reqs_taken, settings_count, rsps_checked);
        $display("statuses seen: %0d done, %0d ends equal, %0d no sign change%s",
                 done_count, equal_count, nosign_count,
                 have_zero ? ", exact-zero end included" : "");
        if (fail_count == 0)
            $display("bisection_cubic_root_unit verification clean");
        else
            $display("bisection_cubic_root_unit verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/bcr_pkg.sv
hdl/bcr_cubic.sv
hdl/bcr_datapath.sv
hdl/bcr_ctrl.sv
hdl/bisection_cubic_root_unit.sv
test/bisection_cubic_root_unit_test.sv
